[rtl/edr_pkg.sv]
package edr_pkg;

    // polynomial for 2^x on a Q16 fraction
    localparam logic [11:0] POLY_C3 = 12'd3638;
    localparam logic [13:0] POLY_C2 = 14'd15743;
    localparam logic [15:0] POLY_C1 = 16'd45426;
    localparam logic [16:0] FRAC_ONE = 17'd65536;
    localparam logic [15:0] FRAC_MASK = 16'hFFFF;
    localparam int unsigned SHIFT_LIMIT = 24;
    localparam logic [40:0] TIME_ERR_LIMIT = 41'h100_0000_0000;

    typedef enum logic [2:0] {
        REG_BLOCKS_PER_EPOCH   = 3'd0,
        REG_TARGET_SPACING     = 3'd1,
        REG_HALF_LIFE          = 3'd2,
        REG_GENESIS_DIFFICULTY = 3'd3,
        REG_MIN_DIFFICULTY     = 3'd4,
        REG_MAX_DIFFICULTY     = 3'd5
    } cfg_index_t;

    // travels alongside the epoch divider
    typedef struct packed {
        logic [31:0] blk_height;
        logic [31:0] chain_length;
        logic [39:0] anchor_ts;
        logic [39:0] parent_time;
        logic [31:0] base;
        logic        bypass;
        logic        past_first_epoch;
    } epoch_tag_t;

    // travels alongside the exponent divider
    typedef struct packed {
        logic [31:0] base;
        logic        bypass;
        logic        late;
    } expo_tag_t;

    // shift decision carried through the polynomial stages
    typedef struct packed {
        logic       bypass;
        logic       left;
        logic       sat_max;
        logic       sat_zero;
        logic [4:0] amt;
    } shift_ctl_t;

endpackage

[rtl/edr_div.sv]
module edr_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 32,
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output logic [DEN_W-1:0] out_rem,
    output logic [TAG_W-1:0] out_tag
);

    // one quotient bit per stage; dividend bits shift out as quotient bits shift in
    logic             valid_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [TAG_W-1:0] tag_reg [NUM_W];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [TAG_W-1:0] tag_in;
        logic             valid_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] nq_next;

        if (g == 0) begin : g_first
            assign rem_in   = '0;
            assign nq_in    = in_num;
            assign tag_in   = in_tag;
            assign valid_in = in_valid;
        end else begin : g_rest
            assign rem_in   = rem_reg[g-1];
            assign nq_in    = nq_reg[g-1];
            assign tag_in   = tag_reg[g-1];
            assign valid_in = valid_reg[g-1];
        end

        assign trial    = {rem_in, nq_in[NUM_W-1]};
        assign diff     = trial - {1'b0, den};
        assign ge       = trial >= {1'b0, den};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign nq_next  = {nq_in[NUM_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (en) begin
                valid_reg[g] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= rem_next;
                nq_reg[g]  <= nq_next;
                tag_reg[g] <= tag_in;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quo   = nq_reg[NUM_W-1];
    assign out_rem   = rem_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];

endmodule

[rtl/exponential_difficulty_retarget.sv]
// channel  | direction | handshake         | payload
// s_       | in        | s_tvalid/s_tready | s_tdata: height, length, anchor time/diff, parent time
// m_       | out       | m_tvalid/m_tready | m_tdata: next_difficulty
// cfg_     | in        | cfg_we            | cfg_index, cfg_wdata
//
// one item per cycle while the result is taken; stages: input register, 32-stage epoch
// divider, 5 time-error stages, 57-stage exponent divider (one quotient bit
// per stage), 6 polynomial/shift stages and the output register.
// aresetn is synchronous; it clears valids and loads register defaults.
// a held result that is not taken freezes the whole pipeline in place.
module exponential_difficulty_retarget (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // blk_height[31:0], chain_length[63:32], anchor_ts[103:64],
    // anchor_difficulty[135:104], parent_time[175:136]
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_difficulty[31:0]
    output logic [31:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    logic [31:0] bpe_reg;
    logic [19:0] spacing_reg;
    logic [24:0] half_life_reg;
    logic [31:0] genesis_reg;
    logic [31:0] min_reg;
    logic [31:0] max_reg;

    // zero epoch length and zero half life behave as one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpe_reg       <= 32'd1024;
            spacing_reg   <= 20'd600;
            half_life_reg <= 25'd172800;
            genesis_reg   <= 32'd65536;
            min_reg       <= 32'd1;
            max_reg       <= 32'hFFFF_FFFF;
        end else if (cfg_we) begin
            unique case (edr_pkg::cfg_index_t'(cfg_index))
                edr_pkg::REG_BLOCKS_PER_EPOCH:
                    bpe_reg <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
                edr_pkg::REG_TARGET_SPACING:     spacing_reg <= cfg_wdata[19:0];
                edr_pkg::REG_HALF_LIFE:
                    half_life_reg <= (cfg_wdata[24:0] == 25'd0) ? 25'd1 : cfg_wdata[24:0];
                edr_pkg::REG_GENESIS_DIFFICULTY: genesis_reg <= cfg_wdata;
                edr_pkg::REG_MIN_DIFFICULTY:     min_reg <= cfg_wdata;
                edr_pkg::REG_MAX_DIFFICULTY:     max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic adv;
    logic m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // input stage
    logic                 in_valid_reg;
    edr_pkg::epoch_tag_t  in_tag_reg;
    edr_pkg::epoch_tag_t  in_tag_next;

    always_comb begin
        in_tag_next.blk_height   = s_tdata[31:0];
        in_tag_next.chain_length = s_tdata[63:32];
        in_tag_next.anchor_ts    = s_tdata[103:64];
        in_tag_next.base         = (s_tdata[135:104] == 32'd0) ? genesis_reg : s_tdata[135:104];
        in_tag_next.parent_time  = s_tdata[175:136];
        in_tag_next.bypass       = (s_tdata[63:32] == 32'd0) || (s_tdata[31:0] == 32'd0);
        in_tag_next.past_first_epoch = s_tdata[31:0] >= bpe_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_tag_reg <= in_tag_next;
        end
    end

    // height modulo epoch length
    logic                d1_valid;
    logic [31:0]         d1_rem;
    edr_pkg::epoch_tag_t d1_tag;

    edr_div #(
        .NUM_W(32),
        .DEN_W(32),
        .TAG_W($bits(edr_pkg::epoch_tag_t))
    ) u_epoch_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (in_valid_reg),
        .in_num   (in_tag_reg.blk_height),
        .den      (bpe_reg),
        .in_tag   (in_tag_reg),
        .out_valid(d1_valid),
        .out_quo  (),
        .out_rem  (d1_rem),
        .out_tag  (d1_tag)
    );

    // stage a: anchor index, parent index, raw time span
    logic        a_valid_reg;
    logic [31:0] a_anchor_reg, a_anchor_next;
    logic [31:0] a_pidx_reg;
    logic [40:0] a_dt_reg;
    logic [31:0] a_base_reg;
    logic        a_bypass_reg;

    assign a_anchor_next = d1_tag.past_first_epoch ?
                           (d1_tag.blk_height - d1_rem - 32'd1) : 32'd0;

    // stage b: blocks between anchor and parent
    logic        b_valid_reg;
    logic [31:0] b_gap_reg, b_gap_next;
    logic [40:0] b_dt_reg;
    logic [31:0] b_base_reg;
    logic        b_bypass_reg;

    assign b_gap_next = (a_anchor_reg > a_pidx_reg) ? 32'd0 : (a_pidx_reg - a_anchor_reg);

    // stage c: expected time
    logic        c_valid_reg;
    logic [51:0] c_expect_reg;
    logic [40:0] c_dt_reg;
    logic [31:0] c_base_reg;
    logic        c_bypass_reg;

    // stage d: schedule error
    logic        d_valid_reg;
    logic [53:0] d_td_reg;
    logic [31:0] d_base_reg;
    logic        d_bypass_reg;

    // stage e: saturated magnitude and sign
    logic        e_valid_reg;
    logic [40:0] e_mag_reg, e_mag_next;
    logic        e_late_reg, e_late_next;
    logic [31:0] e_base_reg;
    logic        e_bypass_reg;
    logic [53:0] e_abs;

    assign e_abs       = d_td_reg[53] ? (54'd0 - d_td_reg) : d_td_reg;
    assign e_late_next = !d_td_reg[53] && (d_td_reg != 54'd0);
    assign e_mag_next  = (e_abs > {13'd0, edr_pkg::TIME_ERR_LIMIT}) ?
                         edr_pkg::TIME_ERR_LIMIT : e_abs[40:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= d1_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_anchor_reg <= a_anchor_next;
            a_pidx_reg   <= d1_tag.chain_length - 32'd1;
            a_dt_reg     <= {1'b0, d1_tag.parent_time} - {1'b0, d1_tag.anchor_ts};
            a_base_reg   <= d1_tag.base;
            a_bypass_reg <= d1_tag.bypass;

            b_gap_reg    <= b_gap_next;
            b_dt_reg     <= a_dt_reg;
            b_base_reg   <= a_base_reg;
            b_bypass_reg <= a_bypass_reg;

            c_expect_reg <= 52'(b_gap_reg) * 52'(spacing_reg);
            c_dt_reg     <= b_dt_reg;
            c_base_reg   <= b_base_reg;
            c_bypass_reg <= b_bypass_reg;

            d_td_reg     <= {{13{c_dt_reg[40]}}, c_dt_reg} - {2'b00, c_expect_reg};
            d_base_reg   <= c_base_reg;
            d_bypass_reg <= c_bypass_reg;

            e_mag_reg    <= e_mag_next;
            e_late_reg   <= e_late_next;
            e_base_reg   <= d_base_reg;
            e_bypass_reg <= d_bypass_reg;
        end
    end

    // |error| * 65536 / half_life
    edr_pkg::expo_tag_t e_tag;
    logic               d2_valid;
    logic [56:0]        d2_quo;
    edr_pkg::expo_tag_t d2_tag;

    assign e_tag.base   = e_base_reg;
    assign e_tag.bypass = e_bypass_reg;
    assign e_tag.late   = e_late_reg;

    edr_div #(
        .NUM_W(57),
        .DEN_W(25),
        .TAG_W($bits(edr_pkg::expo_tag_t))
    ) u_expo_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (e_valid_reg),
        .in_num   ({e_mag_reg, 16'd0}),
        .den      (half_life_reg),
        .in_tag   (e_tag),
        .out_valid(d2_valid),
        .out_quo  (d2_quo),
        .out_rem  (),
        .out_tag  (d2_tag)
    );

    // stage f: fraction and whole shifts; a late chain gives a negative exponent
    logic [40:0]         f_up;
    logic [57:0]         f_ceil;
    logic [41:0]         f_dn;
    edr_pkg::shift_ctl_t f_ctl_next;
    logic [15:0]         f_frac_next;

    assign f_up   = d2_quo[56:16];
    assign f_ceil = {1'b0, d2_quo} + {42'd0, edr_pkg::FRAC_MASK};
    assign f_dn   = f_ceil[57:16];

    always_comb begin
        f_ctl_next.bypass = d2_tag.bypass;
        f_ctl_next.left   = !d2_tag.late;
        if (d2_tag.late) begin
            f_frac_next         = 16'd0 - d2_quo[15:0];
            f_ctl_next.sat_max  = 1'b0;
            f_ctl_next.sat_zero = f_dn > 42'(edr_pkg::SHIFT_LIMIT);
            f_ctl_next.amt      = f_dn[4:0];
        end else begin
            f_frac_next         = d2_quo[15:0];
            f_ctl_next.sat_max  = f_up > 41'(edr_pkg::SHIFT_LIMIT);
            f_ctl_next.sat_zero = 1'b0;
            f_ctl_next.amt      = f_up[4:0];
        end
    end

    logic                f_valid_reg, g_valid_reg, h_valid_reg, i_valid_reg, j_valid_reg;
    logic                k_valid_reg;
    edr_pkg::shift_ctl_t f_ctl_reg, g_ctl_reg, h_ctl_reg, i_ctl_reg, j_ctl_reg, k_ctl_reg;
    logic [15:0]         f_frac_reg, g_frac_reg, h_frac_reg;
    logic [31:0]         f_base_reg, g_base_reg, h_base_reg, i_base_reg;
    logic [14:0]         g_t1_reg;
    logic [15:0]         h_t2_reg;
    logic [16:0]         i_pow_reg;
    logic [48:0]         j_prod_reg;
    logic [56:0]         k_val_reg, k_val_next;

    logic [27:0] g_mul;
    logic [30:0] h_mul;
    logic [31:0] i_mul;
    logic [32:0] k_base;

    assign g_mul  = 28'(edr_pkg::POLY_C3) * 28'(f_frac_reg);
    assign h_mul  = 31'(g_t1_reg) * 31'(g_frac_reg);
    assign i_mul  = 32'(h_t2_reg) * 32'(h_frac_reg);
    assign k_base = j_prod_reg[48:16];
    assign k_val_next = j_ctl_reg.left ? ({24'd0, k_base} << j_ctl_reg.amt)
                                       : {24'd0, k_base >> j_ctl_reg.amt};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= d2_valid;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
            j_valid_reg <= i_valid_reg;
            k_valid_reg <= j_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_ctl_reg  <= f_ctl_next;
            f_frac_reg <= f_frac_next;
            f_base_reg <= d2_tag.base;

            g_t1_reg   <= 15'(edr_pkg::POLY_C2) + 15'(g_mul[27:16]);
            g_ctl_reg  <= f_ctl_reg;
            g_frac_reg <= f_frac_reg;
            g_base_reg <= f_base_reg;

            h_t2_reg   <= edr_pkg::POLY_C1 + h_mul[30:16];
            h_ctl_reg  <= g_ctl_reg;
            h_frac_reg <= g_frac_reg;
            h_base_reg <= g_base_reg;

            i_pow_reg  <= edr_pkg::FRAC_ONE + 17'(i_mul[31:16]);
            i_ctl_reg  <= h_ctl_reg;
            i_base_reg <= h_base_reg;

            j_prod_reg <= 49'(i_base_reg) * 49'(i_pow_reg);
            j_ctl_reg  <= i_ctl_reg;

            k_val_reg  <= k_val_next;
            k_ctl_reg  <= j_ctl_reg;
        end
    end

    // saturation, clamp, and the genesis bypass; the lower bound wins when min is above max
    logic [56:0] l_sat;
    logic [31:0] l_clip;
    logic [31:0] l_result;

    always_comb begin
        if (k_ctl_reg.sat_max) begin
            l_sat = {25'd0, max_reg};
        end else if (k_ctl_reg.sat_zero) begin
            l_sat = '0;
        end else begin
            l_sat = k_val_reg;
        end
        l_clip = (l_sat > {25'd0, max_reg}) ? max_reg : l_sat[31:0];
        priority if (k_ctl_reg.bypass) begin
            l_result = genesis_reg;
        end else if (l_clip < min_reg) begin
            l_result = min_reg;
        end else begin
            l_result = l_clip;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= k_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= l_result;
        end
    end

endmodule
